>>> sv/edsp_pkg.sv
`default_nettype none

package edsp_pkg;

   // fixed field widths
   localparam int CNT_BITS        = 16;
   localparam int TEMP_BITS       = 10;
   localparam int PRESET_BITS     = 16;
   localparam int STEP_SEL_BITS   = 3;
   localparam int STEP_BITS       = 4;
   localparam int MAX_DETENT_JUMP = 20;

   // detent count in the accepted range, plus sign
   localparam int DET_BITS  = $clog2(MAX_DETENT_JUMP + 1) + 1;
   localparam int MOVE_BITS = DET_BITS + STEP_BITS + 1;
   // signed working width for anything that goes through the clamp
   localparam int VAL_BITS  = 18;
   localparam int DELTA_BITS = CNT_BITS + 1;

   // configuration register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 10;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BUTTON_MODE  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_SELECT  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TEMP_FLOOR   = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TEMP_CEILING = 2'd3;

   // request kinds carried on tuser
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_RECALL = 1'b1;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 32;

   typedef struct packed {
      logic [6:0]             pad;
      logic                   hold;
      logic [PRESET_BITS-1:0] preset_value;
      logic [CNT_BITS-1:0]    counter_sample;
   } req_data_type;

   typedef struct packed {
      logic [3:0]           pad;
      logic [CNT_BITS-1:0]  counter_value;
      logic                 counter_write;
      logic                 changed;
      logic [TEMP_BITS-1:0] setpoint;
   } rsp_data_type;

   function automatic logic [STEP_BITS-1:0] step_size(input logic [STEP_SEL_BITS-1:0] sel);
      logic [STEP_BITS-1:0] s;
      case (sel)
         3'd0:    s = 4'd1;
         3'd1:    s = 4'd2;
         3'd2:    s = 4'd5;
         3'd3:    s = 4'd10;
         default: s = 4'd2;
      endcase
      return s;
   endfunction

   // floor is tested first: when the two cross, values below the floor get the floor, all others the ceiling
   function automatic logic [TEMP_BITS-1:0] limit_temp(input logic signed [VAL_BITS-1:0] v,
                                                       input logic [TEMP_BITS-1:0] lo,
                                                       input logic [TEMP_BITS-1:0] hi);
      logic signed [VAL_BITS-1:0] lo_s;
      logic signed [VAL_BITS-1:0] hi_s;
      logic [TEMP_BITS-1:0]       r;
      lo_s = $signed(VAL_BITS'(lo));
      hi_s = $signed(VAL_BITS'(hi));
      if (v < lo_s) begin
         r = lo;
      end else if (v > hi_s) begin
         r = hi;
      end else begin
         r = v[TEMP_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> sv/encoder_detent_setpoint_core.sv
// channel   | direction | tdata (lsb up)                                | tuser
// ----------+-----------+-----------------------------------------------+--------------
// req_      | in        | counter_sample[15:0] preset_value[31:16]      | mode
//           |           | hold[32], zero pad to 40                      |
// rsp_      | out       | setpoint[9:0] changed[10] counter_write[11]   | -
//           |           | counter_value[27:12], zero pad to 32          |
// csr_      | in        | csr_addr selects register, csr_wdata[9:0]     | -
//
// one request per cycle while rsp_tready is high; its response appears in the cycle after acceptance.
// a tick in encoder mode is a single registered pass: wrap delta, detent halving, step multiply, clamp.
// reset is synchronous: configuration to defaults, anchor cleared, setpoint zero.
// a stalled response keeps req_tready low only while rsp_tready is low.
`default_nettype none

module encoder_detent_setpoint_core
   import edsp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,   // counter_sample, preset_value, hold
   input  wire logic                     req_tuser,   // mode
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // setpoint, changed, counter_write, counter_value
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic                     button_mode_ff;
   logic [STEP_SEL_BITS-1:0] step_select_ff;
   logic [TEMP_BITS-1:0]     temp_floor_ff;
   logic [TEMP_BITS-1:0]     temp_ceiling_ff;

   logic                     anchored_ff, anchored_in;
   logic [CNT_BITS-1:0]      anchor_ff, anchor_in;
   logic [TEMP_BITS-1:0]     setpoint_ff, setpoint_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_data_type             rsp_data_ff, rsp_data_in;

   req_data_type             req;
   logic                     accept;
   logic [CNT_BITS-1:0]      anchor_eff;
   logic [CNT_BITS-1:0]      diff;
   logic signed [DELTA_BITS-1:0] delta;
   logic [DELTA_BITS-1:0]    delta_adj;
   logic signed [DELTA_BITS-1:0] detents;
   logic                     big_jump;
   logic signed [MOVE_BITS-1:0]  move;
   logic signed [VAL_BITS-1:0]   moved;
   logic [TEMP_BITS-1:0]     clamped;

   localparam logic signed [DELTA_BITS-1:0] JUMP_POS = DELTA_BITS'(MAX_DETENT_JUMP);
   localparam logic signed [DELTA_BITS-1:0] JUMP_NEG = -JUMP_POS;
   localparam logic [CNT_BITS-1:0] CNT_HALF = {1'b1, {(CNT_BITS-1){1'b0}}};

   assign req         = req_data_type'(req_tdata);
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         button_mode_ff  <= 1'b0;
         step_select_ff  <= 3'd1;
         temp_floor_ff   <= 10'd100;
         temp_ceiling_ff <= 10'd450;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BUTTON_MODE:  button_mode_ff  <= csr_wdata[0];
            CSR_STEP_SELECT:  step_select_ff  <= csr_wdata[STEP_SEL_BITS-1:0];
            CSR_TEMP_FLOOR:   temp_floor_ff   <= csr_wdata[TEMP_BITS-1:0];
            CSR_TEMP_CEILING: temp_ceiling_ff <= csr_wdata[TEMP_BITS-1:0];
         endcase
      end
   end

   // detent arithmetic
   always_comb begin
      anchor_eff = anchored_ff ? anchor_ff : req.counter_sample;
      diff       = req.counter_sample - anchor_eff;
      // above half range counts as a backward turn
      delta      = (diff > CNT_HALF) ? $signed({1'b1, diff}) : $signed({1'b0, diff});
      // halve toward zero
      delta_adj  = delta + DELTA_BITS'(delta[DELTA_BITS-1]);
      detents    = $signed(delta_adj) >>> 1;
      big_jump   = (detents > JUMP_POS) || (detents < JUMP_NEG);
      move       = $signed(detents[DET_BITS-1:0]) * $signed({1'b0, step_size(step_select_ff)});
      moved      = $signed(VAL_BITS'(setpoint_ff)) + VAL_BITS'(move);
   end

   always_comb begin
      anchored_in  = anchored_ff;
      anchor_in    = anchor_ff;
      setpoint_in  = setpoint_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      clamped      = '0;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.pad           = '0;
         rsp_data_in.counter_write = 1'b0;
         rsp_data_in.counter_value = '0;
         if (req_tuser == MODE_RECALL) begin
            setpoint_in = limit_temp($signed(VAL_BITS'(req.preset_value)),
                                     temp_floor_ff, temp_ceiling_ff);
         end else if (!req.hold) begin
            if (button_mode_ff) begin
               clamped     = limit_temp($signed(VAL_BITS'(req.counter_sample)),
                                        temp_floor_ff, temp_ceiling_ff);
               setpoint_in = clamped;
               rsp_data_in.counter_write = 1'b1;
               rsp_data_in.counter_value = CNT_BITS'(clamped);
            end else begin
               anchored_in = 1'b1;
               anchor_in   = anchor_eff;
               if (detents != '0) begin
                  if (big_jump) begin
                     anchor_in = req.counter_sample;
                  end else begin
                     anchor_in   = anchor_eff + {detents[CNT_BITS-2:0], 1'b0};
                     setpoint_in = limit_temp(moved, temp_floor_ff, temp_ceiling_ff);
                  end
               end
            end
         end
         rsp_data_in.setpoint = setpoint_in;
         rsp_data_in.changed  = (req_tuser == MODE_TICK) && (setpoint_in != setpoint_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchored_ff  <= 1'b0;
         anchor_ff    <= '0;
         setpoint_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         anchored_ff  <= anchored_in;
         anchor_ff    <= anchor_in;
         setpoint_ff  <= setpoint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // once synced the anchor stays valid
   a_anchor_sticky: assert property (@(posedge clock) disable iff (reset)
      anchored_ff |=> anchored_ff)
      else $error("anchor lost without reset");

   // a recall never flags a change or a counter write
   a_recall_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == MODE_RECALL |=> !rsp_data_ff.changed && !rsp_data_ff.counter_write)
      else $error("recall response flagged change or write");

   // the written-back counter is the setpoint itself
   a_write_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.counter_write |->
         rsp_data_ff.counter_value == CNT_BITS'(rsp_data_ff.setpoint))
      else $error("counter write value differs from setpoint");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.counter_write |-> rsp_data_ff.counter_value == '0)
      else $error("counter value set without write");

   // response shows the stored setpoint after its request
   a_setpoint_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_data_ff.setpoint == setpoint_ff)
      else $error("response setpoint differs from state");

endmodule

`default_nettype wire

>>> tb/setpoint_check_pkg.sv
`default_nettype none

package setpoint_check_pkg;
   import edsp_pkg::*;

   class setpoint_scoreboard;
      // register copies
      logic                   button_mode;
      logic [STEP_SEL_BITS-1:0] step_select;
      logic [TEMP_BITS-1:0]   temp_floor;
      logic [TEMP_BITS-1:0]   temp_ceiling;
      // block state
      logic                   anchored;
      logic [CNT_BITS-1:0]    anchor_count;
      logic [TEMP_BITS-1:0]   setpoint;

      rsp_data_type           expected_rsp[$];
      int                     errors;
      int                     n_requests;
      int                     n_changed;
      int                     n_writeback;

      function new();
         button_mode  = 1'b0;
         step_select  = 3'd1;
         temp_floor   = 10'd100;
         temp_ceiling = 10'd450;
         anchored     = 1'b0;
         anchor_count = '0;
         setpoint     = '0;
         errors       = 0;
         n_requests   = 0;
         n_changed    = 0;
         n_writeback  = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] data);
         case (addr)
            CSR_BUTTON_MODE:  button_mode  = data[0];
            CSR_STEP_SELECT:  step_select  = data[STEP_SEL_BITS-1:0];
            CSR_TEMP_FLOOR:   temp_floor   = data[TEMP_BITS-1:0];
            CSR_TEMP_CEILING: temp_ceiling = data[TEMP_BITS-1:0];
            default: ;
         endcase
      endfunction

      // floor is tested first: when the limits cross, values below the floor get the floor, all others the ceiling
      function logic [TEMP_BITS-1:0] clamp(int v);
         logic [TEMP_BITS-1:0] r;
         if (v < int'(temp_floor)) begin
            r = temp_floor;
         end else if (v > int'(temp_ceiling)) begin
            r = temp_ceiling;
         end else begin
            r = v[TEMP_BITS-1:0];
         end
         return r;
      endfunction

      function void note_request(logic mode, logic [CNT_BITS-1:0] sample,
                                 logic [PRESET_BITS-1:0] preset, logic hold);
         rsp_data_type        r;
         logic [TEMP_BITS-1:0] prev_sp;
         logic [CNT_BITS-1:0] diff;
         int                  delta;
         int                  detents;
         int                  step;
         r = '0;
         prev_sp = setpoint;
         if (mode == MODE_RECALL) begin
            setpoint = clamp(int'(preset));
            prev_sp = setpoint;
         end else if (!hold) begin
            if (button_mode) begin
               setpoint = clamp(int'(sample));
               r.counter_write = 1'b1;
               r.counter_value = CNT_BITS'(setpoint);
            end else begin
               case (step_select)
                  3'd0:    step = 1;
                  3'd1:    step = 2;
                  3'd2:    step = 5;
                  3'd3:    step = 10;
                  default: step = 2;
               endcase
               if (!anchored) begin
                  anchor_count = sample;
                  anchored = 1'b1;
               end
               diff = sample - anchor_count;
               delta = int'(diff);
               // exactly half the range stays positive
               if (delta > (1 << (CNT_BITS - 1))) delta -= (1 << CNT_BITS);
               detents = delta / 2;
               if (detents != 0) begin
                  if (detents > MAX_DETENT_JUMP || detents < -MAX_DETENT_JUMP) begin
                     anchor_count = sample;
                  end else begin
                     // whole detents only, odd remainder stays pending
                     anchor_count = anchor_count + CNT_BITS'(detents * 2);
                     setpoint = clamp(int'(setpoint) + detents * step);
                  end
               end
            end
         end
         r.setpoint = setpoint;
         r.changed  = (setpoint != prev_sp);
         expected_rsp.push_back(r);
         n_requests++;
         if (r.changed) n_changed++;
         if (r.counter_write) n_writeback++;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         if (errors < 40) begin
            $display("mismatch on %s: got %0d expected %0d (%0d requests in)",
                     what, got, want, n_requests);
         end
         errors++;
      endtask

      task check_response(logic [RSP_DATA_BITS-1:0] raw);
         rsp_data_type got;
         rsp_data_type want;
         got = raw;
         if (expected_rsp.size() == 0) begin
            report("response with no request outstanding", 32'(got.setpoint), 32'd0);
            return;
         end
         want = expected_rsp.pop_front();
         if (got.setpoint !== want.setpoint)
            report("setpoint", 32'(got.setpoint), 32'(want.setpoint));
         if (got.changed !== want.changed)
            report("changed", 32'(got.changed), 32'(want.changed));
         if (got.counter_write !== want.counter_write)
            report("counter_write", 32'(got.counter_write), 32'(want.counter_write));
         if (got.counter_value !== want.counter_value)
            report("counter_value", 32'(got.counter_value), 32'(want.counter_value));
      endtask

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

endpackage

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import edsp_pkg::*;
   import setpoint_check_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;    // counter_sample, preset_value, hold
   logic                     req_tuser = MODE_TICK;   // mode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // setpoint, changed, counter_write, counter_value
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   setpoint_scoreboard       sb;
   logic [CNT_BITS-1:0]      last_sample = '0;
   int                       burst_left = 0;
   int                       n_settings = 0;
   logic [15:0]              stall_bits = '0;
   logic [7:0]               stall_phase = '0;

   encoder_detent_setpoint_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // receiver stall pattern, chosen anew each time stall_phase wraps to zero; bit 0 kept clear so it never locks up
   always @(posedge clock) begin
      if (stall_phase == 8'd0) begin
         case ($urandom_range(0, 3))
            0: stall_bits <= 16'h0000;
            1: stall_bits <= 16'($urandom) & 16'hFFFE;
            2: stall_bits <= 16'($urandom & $urandom) & 16'hFFFE;
            default: stall_bits <= 16'hAAAA;
         endcase
      end
      stall_phase <= stall_phase + 8'd1;
      rsp_tready <= !stall_bits[stall_phase[3:0]];
   end

   always @(posedge clock) begin
      req_data_type d;
      d = req_tdata;
      if (!reset) begin
         // a response accepted now belongs to an earlier request
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, d.counter_sample, d.preset_value, d.hold);
      end
   end

   task automatic send_request(input logic mode, input logic [CNT_BITS-1:0] sample,
                               input logic [PRESET_BITS-1:0] preset, input logic hold);
      req_data_type d;
      int           gap;
      d = '0;
      d.counter_sample = sample;
      d.preset_value   = preset;
      d.hold           = hold;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_TICK) last_sample = sample;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic bm, input logic [STEP_SEL_BITS-1:0] step,
                            input logic [TEMP_BITS-1:0] lo, input logic [TEMP_BITS-1:0] hi);
      logic [CSR_ADDR_BITS-1:0] addr;
      logic [CSR_DATA_BITS-1:0] data;
      for (int i = 0; i < 4; i++) begin
         addr = CSR_ADDR_BITS'(i);
         case (addr)
            CSR_BUTTON_MODE:  data = CSR_DATA_BITS'(bm);
            CSR_STEP_SELECT:  data = CSR_DATA_BITS'(step);
            CSR_TEMP_FLOOR:   data = lo;
            default:          data = hi;
         endcase
         csr_we    <= 1'b1;
         csr_addr  <= addr;
         csr_wdata <= data;
         sb.write_reg(addr, data);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // mostly small knob turns near the last sample, or 0 to 1100 in button mode; also recalls, holds and wild jumps
   task automatic random_items(input int n);
      int                  pick;
      int                  offset;
      logic [CNT_BITS-1:0] s;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_request(MODE_RECALL, 16'($urandom), 16'($urandom), 1'($urandom));
         end else if (pick <= 2) begin
            send_request(MODE_RECALL, 16'($urandom), 16'($urandom_range(0, 1100)), 1'($urandom));
         end else if (pick <= 4) begin
            send_request(MODE_TICK, 16'($urandom), 16'($urandom), 1'b1);
         end else if (pick == 5) begin
            send_request(MODE_TICK, 16'($urandom), 16'($urandom), 1'b0);
         end else begin
            if (sb.button_mode) begin
               s = 16'($urandom_range(0, 1100));
            end else begin
               offset = int'($urandom_range(0, 92)) - 46;
               s = last_sample + 16'(offset);
            end
            send_request(MODE_TICK, s, 16'($urandom), 1'b0);
         end
      end
   endtask

   initial begin
      logic [TEMP_BITS-1:0] lo;
      logic [TEMP_BITS-1:0] hi;
      logic [TEMP_BITS-1:0] swap;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: anchoring, detents, jump limits, recall and wrap
      send_request(MODE_TICK, 16'h1234, 16'h0000, 1'b1);
      send_request(MODE_TICK, 16'h1234, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h1236, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h1237, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h1238, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h1260, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h128A, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h1262, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h1238, 16'h0000, 1'b0);
      send_request(MODE_RECALL, 16'h0000, 16'hFFFF, 1'b1);
      send_request(MODE_RECALL, 16'hFFFF, 16'h0000, 1'b0);
      send_request(MODE_RECALL, 16'h0000, 16'd300, 1'b0);
      send_request(MODE_TICK, 16'hFFFF, 16'h0000, 1'b1);
      send_request(MODE_TICK, 16'hFFFE, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h0002, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'hFFFE, 16'h0000, 1'b0);
      // exactly half the range forward, then one past it
      send_request(MODE_TICK, 16'h7FFE, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'hFFFF, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'h0000, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'hFFFD, 16'h0000, 1'b0);
      // minus one count rounds toward zero
      send_request(MODE_TICK, 16'hFFFC, 16'h0000, 1'b0);
      settle();

      configure(1'b1, 3'd1, 10'd0, 10'd1023);
      send_request(MODE_TICK, 16'h0000, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'hFFFF, 16'h0000, 1'b0);
      send_request(MODE_TICK, 16'd500, 16'h0000, 1'b1);
      send_request(MODE_TICK, 16'd700, 16'h0000, 1'b0);
      random_items(34);
      settle();

      configure(1'b0, 3'd0, 10'd0, 10'd1023);
      random_items(34);
      settle();
      configure(1'b0, 3'd3, 10'd1023, 10'd1023);
      random_items(34);
      settle();
      configure(1'b0, 3'd7, 10'd500, 10'd200);
      random_items(34);
      settle();
      configure(1'b1, 3'd5, 10'd500, 10'd200);
      random_items(34);
      settle();
      configure(1'b0, 3'd2, 10'd100, 10'd450);
      random_items(34);
      settle();
      configure(1'b0, 3'd4, 10'd0, 10'd0);
      random_items(34);
      settle();

      for (int p = 0; p < 5; p++) begin
         lo = 10'($urandom_range(0, 1023));
         hi = 10'($urandom_range(0, 1023));
         if (lo > hi && $urandom_range(0, 3) != 0) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         configure($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), lo, hi);
         random_items(34);
         settle();
      end

      $display("covered %0d requests under %0d register settings", sb.n_requests, n_settings + 1);
      $display("%0d setpoint changes, %0d counter write-backs, %0d mismatches",
               sb.n_changed, sb.n_writeback, sb.errors);
      if (sb.errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

>>> encoder_detent_setpoint_core.f
sv/edsp_pkg.sv
sv/encoder_detent_setpoint_core.sv
tb/setpoint_check_pkg.sv
tb/tb_top.sv
